[rtl/vrt_pkg.sv]
// Shared types and constants of the voxel ray traversal block.
// Used by vrt_ctrl, vrt_datapath and voxel_ray_traversal_top; depends on nothing.
package vrt_pkg;

    localparam int COORD_FRAC_BITS = 8;
    localparam int DIR_FRAC_BITS   = 14;
    localparam int T_FRAC          = 16;
    localparam int OUT_FRAC        = 8;
    localparam int MAX_RESULTS     = 64;

    localparam int ORG_W   = 24;
    localparam int DIR_W   = 16;
    localparam int CELL_W  = 16;
    localparam int TRAV_W  = 13;
    localparam int MD_W    = 5;
    localparam int S_W     = 32;
    localparam int LEN_W   = 16;
    localparam int DIFF_W  = COORD_FRAC_BITS + 1;
    localparam int PROD_W  = DIFF_W + LEN_W;
    localparam int DIV_W   = 32;
    localparam int DCNT_W  = 5;
    localparam int T_W     = 40;
    localparam int REACH_W = MD_W + T_FRAC;
    localparam int N_W     = 6;

    localparam logic [MD_W-1:0]   MD_RESET   = 5'd8;
    localparam logic [TRAV_W-1:0] TRAVEL_SAT = 13'd4607;
    localparam logic [N_W-1:0]    LAST_N     = N_W'(MAX_RESULTS - 1);
    localparam logic [DCNT_W-1:0] DIV_LAST   = DCNT_W'(DIV_W - 1);
    localparam logic [S_W-1:0]    ROOT_BIT0  = S_W'(1) << (S_W - 2);
    localparam logic [T_W-1:0]    T_INF      = T_W'(1) << (T_W - 1);

    localparam logic [63:0] DEGEN_LIM64 =
        ((64'd1 << (2 * DIR_FRAC_BITS)) - 64'd1) / 64'd1000000000000;
    localparam logic [S_W-1:0] DEGEN_LIM = DEGEN_LIM64[S_W-1:0];

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_RINIT,
        ST_ROOT,
        ST_SETUP,
        ST_DDIV,
        ST_DSTORE,
        ST_TDIV,
        ST_TSTORE,
        ST_FIRST,
        ST_WALK
    } vrt_state_t;

    typedef struct packed {
        logic       load;
        logic       sq;
        logic       root_init;
        logic       root_step;
        logic       setup;
        logic       div_step;
        logic       dstore;
        logic       tstore;
        logic       emit_first;
        logic       walk;
        logic [1:0] axis;
    } vrt_cmd_t;

    typedef struct packed {
        logic out_free;
        logic root_last;
        logic degen;
        logic axis_zero;
        logic walk_last;
    } vrt_status_t;

endpackage

[rtl/voxel_ray_traversal_top.sv]
// Top level of the voxel ray traversal block: stream ports, reach register,
// sequencer and datapath. Depends on vrt_pkg, vrt_ctrl and vrt_datapath.
//
//  channel   dir   handshake                       payload
//  s_axis    in    s_axis_tvalid / s_axis_tready   one ray per item (tdata)
//  m_axis    out   m_axis_tvalid / m_axis_tready   one visited cell per item
//  cfg       in    cfg_wr_en                       max_distance (cfg_wr_data)
//
// Sequence: a ray is accepted, the three squares are summed, the root is set up and found in 16
// steps, then each axis with nonzero direction gets a setup, two 32-step divides and two stores,
// a zero axis only its setup, and a degenerate ray skips the axes; then one cell is emitted per
// cycle while m_axis takes them. The divider is bit-serial and restoring.
// Reset clears the sequencer, the output valid and sets the reach to 8 voxels.
// A stalled m_axis holds the walk; the next ray is taken once the final cell of the
// current one sits in the output register.
module voxel_ray_traversal_top
(
    input  logic         clk,
    input  logic         rst_n,
    // origin_x[23:0], origin_y[47:24], origin_z[71:48],
    // dir_x[87:72], dir_y[103:88], dir_z[119:104]
    input  logic [119:0] s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cell_x[15:0], cell_y[31:16], cell_z[47:32], prev_x[63:48],
    // prev_y[79:64], prev_z[95:80], travelled[108:96], zero pad [111:109]
    output logic [111:0] m_axis_tdata,
    // degenerate[0]
    output logic         m_axis_tuser,
    output logic         m_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         cfg_wr_en,
    input  logic [4:0]   cfg_wr_data
);

    logic [vrt_pkg::MD_W-1:0] max_distance_reg;

    vrt_pkg::vrt_cmd_t    cmd;
    vrt_pkg::vrt_status_t status;

    logic signed [vrt_pkg::CELL_W-1:0] cell_x, cell_y, cell_z;
    logic signed [vrt_pkg::CELL_W-1:0] prev_x, prev_y, prev_z;
    logic [vrt_pkg::TRAV_W-1:0]        travelled;

    // reach register; the user must write it only while no ray is in flight, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_distance_reg <= vrt_pkg::MD_RESET;
        else if (cfg_wr_en)
            max_distance_reg <= cfg_wr_data;
    end

    vrt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    vrt_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .max_distance (max_distance_reg),
        .origin_x     (s_axis_tdata[23:0]),
        .origin_y     (s_axis_tdata[47:24]),
        .origin_z     (s_axis_tdata[71:48]),
        .dir_x        (s_axis_tdata[87:72]),
        .dir_y        (s_axis_tdata[103:88]),
        .dir_z        (s_axis_tdata[119:104]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_z       (cell_z),
        .prev_x       (prev_x),
        .prev_y       (prev_y),
        .prev_z       (prev_z),
        .travelled    (travelled),
        .degenerate   (m_axis_tuser),
        .last         (m_axis_tlast)
    );

    // pack the result item, pad to whole bytes
    assign m_axis_tdata = {3'b000, travelled, prev_z, prev_y, prev_x, cell_z, cell_y, cell_x};

endmodule

[rtl/vrt_ctrl.sv]
// Sequencer of the voxel ray traversal block: square sum, root, divides, walk.
// Depends on vrt_pkg; drives vrt_datapath by command struct.
module vrt_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vrt_pkg::vrt_status_t status,
    output vrt_pkg::vrt_cmd_t    cmd
);

    vrt_pkg::vrt_state_t            state_reg, state_next;
    logic [1:0]                     ax_reg, ax_next;
    logic [vrt_pkg::DCNT_W-1:0]     cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vrt_pkg::ST_IDLE;
            ax_reg    <= vrt_pkg::AXIS_X;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        ax_next    = ax_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            vrt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = vrt_pkg::ST_SQ;
                    ax_next    = vrt_pkg::AXIS_X;
                end
            end
            vrt_pkg::ST_SQ:
            begin
                if (ax_reg == vrt_pkg::AXIS_Z)
                    state_next = vrt_pkg::ST_RINIT;
                else
                    ax_next = ax_reg + 2'd1;
            end
            vrt_pkg::ST_RINIT:
                state_next = vrt_pkg::ST_ROOT;
            vrt_pkg::ST_ROOT:
            begin
                if (status.root_last)
                begin
                    ax_next    = vrt_pkg::AXIS_X;
                    state_next = status.degen ? vrt_pkg::ST_FIRST : vrt_pkg::ST_SETUP;
                end
            end
            vrt_pkg::ST_SETUP:
            begin
                cnt_next = '0;
                if (!status.axis_zero)
                    state_next = vrt_pkg::ST_DDIV;
                else if (ax_reg == vrt_pkg::AXIS_Z)
                    state_next = vrt_pkg::ST_FIRST;
                else
                    ax_next = ax_reg + 2'd1;
            end
            vrt_pkg::ST_DDIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == vrt_pkg::DIV_LAST)
                    state_next = vrt_pkg::ST_DSTORE;
            end
            vrt_pkg::ST_DSTORE:
            begin
                cnt_next   = '0;
                state_next = vrt_pkg::ST_TDIV;
            end
            vrt_pkg::ST_TDIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == vrt_pkg::DIV_LAST)
                    state_next = vrt_pkg::ST_TSTORE;
            end
            vrt_pkg::ST_TSTORE:
            begin
                if (ax_reg == vrt_pkg::AXIS_Z)
                    state_next = vrt_pkg::ST_FIRST;
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = vrt_pkg::ST_SETUP;
                end
            end
            vrt_pkg::ST_FIRST:
            begin
                if (status.out_free)
                    state_next = status.degen ? vrt_pkg::ST_IDLE : vrt_pkg::ST_WALK;
            end
            vrt_pkg::ST_WALK:
            begin
                if (status.out_free && status.walk_last)
                    state_next = vrt_pkg::ST_IDLE;
            end
            default:
                state_next = vrt_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        cmd.axis = ax_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            vrt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            vrt_pkg::ST_SQ:     cmd.sq        = 1'b1;
            vrt_pkg::ST_RINIT:  cmd.root_init = 1'b1;
            vrt_pkg::ST_ROOT:   cmd.root_step = 1'b1;
            vrt_pkg::ST_SETUP:  cmd.setup     = 1'b1;
            vrt_pkg::ST_DDIV:   cmd.div_step  = 1'b1;
            vrt_pkg::ST_DSTORE: cmd.dstore    = 1'b1;
            vrt_pkg::ST_TDIV:   cmd.div_step  = 1'b1;
            vrt_pkg::ST_TSTORE: cmd.tstore    = 1'b1;
            vrt_pkg::ST_FIRST:  cmd.emit_first = status.out_free;
            vrt_pkg::ST_WALK:   cmd.walk      = status.out_free;
            default:            cmd           = '0;
        endcase
    end

endmodule

[rtl/vrt_datapath.sv]
// Datapath of the voxel ray traversal block: square sum, bit-serial root,
// restoring divider, per-axis DDA registers and the output register. Depends on vrt_pkg.
module vrt_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  vrt_pkg::vrt_cmd_t                   cmd,
    output vrt_pkg::vrt_status_t                status,
    input  logic [vrt_pkg::MD_W-1:0]            max_distance,
    input  logic signed [vrt_pkg::ORG_W-1:0]    origin_x,
    input  logic signed [vrt_pkg::ORG_W-1:0]    origin_y,
    input  logic signed [vrt_pkg::ORG_W-1:0]    origin_z,
    input  logic signed [vrt_pkg::DIR_W-1:0]    dir_x,
    input  logic signed [vrt_pkg::DIR_W-1:0]    dir_y,
    input  logic signed [vrt_pkg::DIR_W-1:0]    dir_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vrt_pkg::CELL_W-1:0]   cell_x,
    output logic signed [vrt_pkg::CELL_W-1:0]   cell_y,
    output logic signed [vrt_pkg::CELL_W-1:0]   cell_z,
    output logic signed [vrt_pkg::CELL_W-1:0]   prev_x,
    output logic signed [vrt_pkg::CELL_W-1:0]   prev_y,
    output logic signed [vrt_pkg::CELL_W-1:0]   prev_z,
    output logic [vrt_pkg::TRAV_W-1:0]          travelled,
    output logic                                degenerate,
    output logic                                last
);

    localparam int CFB = vrt_pkg::COORD_FRAC_BITS;

    logic signed [vrt_pkg::ORG_W-1:0]  org_reg   [3];
    logic signed [vrt_pkg::DIR_W-1:0]  dir_reg   [3];
    logic signed [vrt_pkg::CELL_W-1:0] cur_reg   [3];
    logic [vrt_pkg::T_W-1:0]           tmax_reg  [3];
    logic [vrt_pkg::DIV_W-1:0]         tdelta_reg[3];

    logic [vrt_pkg::S_W-1:0]    s_reg;
    logic [vrt_pkg::S_W-1:0]    rem_reg;
    logic [vrt_pkg::S_W-1:0]    root_reg;
    logic [vrt_pkg::S_W-1:0]    bit_reg;
    logic [vrt_pkg::PROD_W-1:0] prod_reg;
    logic [vrt_pkg::DIV_W-1:0]  dvd_reg;
    logic [vrt_pkg::DIR_W-1:0]  drem_reg;
    logic [vrt_pkg::N_W-1:0]    n_reg;

    logic                                out_valid_reg;
    logic signed [vrt_pkg::CELL_W-1:0]   cell_reg [3];
    logic signed [vrt_pkg::CELL_W-1:0]   prev_reg [3];
    logic [vrt_pkg::TRAV_W-1:0]          trav_reg;
    logic                                degen_reg;
    logic                                last_reg;

    // selected axis for squares, setup and divides
    logic signed [vrt_pkg::DIR_W-1:0]  d_sel;
    logic                              neg_sel;
    logic [vrt_pkg::DIR_W-1:0]         ad_sel;
    logic [CFB-1:0]                    frac_sel;
    logic [vrt_pkg::DIFF_W-1:0]        diff_sel;
    logic signed [2*vrt_pkg::DIR_W-1:0] sq_val;
    logic [vrt_pkg::LEN_W-1:0]         len;
    logic [vrt_pkg::S_W:0]             root_sum;
    logic [vrt_pkg::DIR_W:0]           trial;
    logic                              qbit;
    logic [vrt_pkg::DIR_W-1:0]         trial_sub;

    // walk step
    logic [1:0]                        k;
    logic [vrt_pkg::T_W-1:0]           t_new;
    logic signed [vrt_pkg::CELL_W-1:0] cur_step;
    logic [vrt_pkg::T_W-1:0]           reach;
    logic [vrt_pkg::T_W-1-vrt_pkg::OUT_FRAC:0] trav_full;
    logic [vrt_pkg::TRAV_W-1:0]        trav_sat;

    assign d_sel     = dir_reg[cmd.axis];
    assign neg_sel   = d_sel[vrt_pkg::DIR_W-1];
    assign ad_sel    = neg_sel ? vrt_pkg::DIR_W'(-d_sel) : vrt_pkg::DIR_W'(d_sel);
    assign frac_sel  = org_reg[cmd.axis][CFB-1:0];
    assign diff_sel  = neg_sel ? {1'b0, frac_sel}
                               : (vrt_pkg::DIFF_W'(1) << CFB) - {1'b0, frac_sel};
    assign sq_val    = d_sel * d_sel;
    assign len       = root_reg[vrt_pkg::LEN_W-1:0];
    assign root_sum  = {1'b0, root_reg} + {1'b0, bit_reg};
    assign trial     = {drem_reg, dvd_reg[vrt_pkg::DIV_W-1]};
    assign qbit      = (trial >= {1'b0, ad_sel});
    assign trial_sub = vrt_pkg::DIR_W'(trial - {1'b0, ad_sel});

    always_comb
    begin
        if (tmax_reg[0] < tmax_reg[1] && tmax_reg[0] < tmax_reg[2])
            k = vrt_pkg::AXIS_X;
        else if (tmax_reg[1] < tmax_reg[2])
            k = vrt_pkg::AXIS_Y;
        else
            k = vrt_pkg::AXIS_Z;
    end

    assign t_new     = tmax_reg[k];
    assign cur_step  = dir_reg[k][vrt_pkg::DIR_W-1] ? cur_reg[k] - 16'sd1
                                                    : cur_reg[k] + 16'sd1;
    assign reach     = vrt_pkg::T_W'({max_distance, {vrt_pkg::T_FRAC{1'b0}}});
    assign trav_full = t_new[vrt_pkg::T_W-1:vrt_pkg::OUT_FRAC];
    assign trav_sat  = (trav_full > (vrt_pkg::T_W-vrt_pkg::OUT_FRAC)'(vrt_pkg::TRAVEL_SAT))
                       ? vrt_pkg::TRAVEL_SAT : trav_full[vrt_pkg::TRAV_W-1:0];

    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.root_last = bit_reg[0];
    assign status.degen     = (s_reg <= vrt_pkg::DEGEN_LIM);
    assign status.axis_zero = (d_sel == '0);
    assign status.walk_last = (t_new > reach) || (n_reg == vrt_pkg::LAST_N);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_first || cmd.walk)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            org_reg[0] <= origin_x;
            org_reg[1] <= origin_y;
            org_reg[2] <= origin_z;
            dir_reg[0] <= dir_x;
            dir_reg[1] <= dir_y;
            dir_reg[2] <= dir_z;
            cur_reg[0] <= vrt_pkg::CELL_W'(origin_x >>> CFB);
            cur_reg[1] <= vrt_pkg::CELL_W'(origin_y >>> CFB);
            cur_reg[2] <= vrt_pkg::CELL_W'(origin_z >>> CFB);
            s_reg      <= '0;
        end

        if (cmd.sq)
            s_reg <= s_reg + vrt_pkg::S_W'(sq_val);

        if (cmd.root_init)
        begin
            rem_reg  <= s_reg;
            root_reg <= '0;
            bit_reg  <= vrt_pkg::ROOT_BIT0;
        end

        if (cmd.root_step)
        begin
            if ({1'b0, rem_reg} >= root_sum)
            begin
                rem_reg  <= rem_reg - root_sum[vrt_pkg::S_W-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
                root_reg <= root_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end

        if (cmd.setup)
        begin
            if (d_sel == '0)
                tmax_reg[cmd.axis] <= vrt_pkg::T_INF;
            else
            begin
                dvd_reg  <= vrt_pkg::DIV_W'({len, {vrt_pkg::T_FRAC{1'b0}}});
                drem_reg <= '0;
                prod_reg <= diff_sel * len;
            end
        end

        if (cmd.div_step)
        begin
            drem_reg <= qbit ? trial_sub : trial[vrt_pkg::DIR_W-1:0];
            dvd_reg  <= {dvd_reg[vrt_pkg::DIV_W-2:0], qbit};
        end

        if (cmd.dstore)
        begin
            tdelta_reg[cmd.axis] <= dvd_reg;
            dvd_reg  <= vrt_pkg::DIV_W'(64'(prod_reg) << (vrt_pkg::T_FRAC - CFB));
            drem_reg <= '0;
        end

        if (cmd.tstore)
            tmax_reg[cmd.axis] <= vrt_pkg::T_W'(dvd_reg);

        if (cmd.emit_first)
        begin
            n_reg <= vrt_pkg::N_W'(1);
            for (int i = 0; i < 3; i++)
            begin
                cell_reg[i] <= cur_reg[i];
                prev_reg[i] <= cur_reg[i];
            end
            trav_reg  <= '0;
            degen_reg <= status.degen;
            last_reg  <= status.degen;
        end

        if (cmd.walk)
        begin
            n_reg       <= n_reg + 1'b1;
            cur_reg[k]  <= cur_step;
            tmax_reg[k] <= tmax_reg[k] + vrt_pkg::T_W'(tdelta_reg[k]);
            for (int i = 0; i < 3; i++)
            begin
                prev_reg[i] <= cur_reg[i];
                cell_reg[i] <= (k == 2'(i)) ? cur_step : cur_reg[i];
            end
            trav_reg  <= trav_sat;
            degen_reg <= 1'b0;
            last_reg  <= status.walk_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_x     = cell_reg[0];
    assign cell_y     = cell_reg[1];
    assign cell_z     = cell_reg[2];
    assign prev_x     = prev_reg[0];
    assign prev_y     = prev_reg[1];
    assign prev_z     = prev_reg[2];
    assign travelled  = trav_reg;
    assign degenerate = degen_reg;
    assign last       = last_reg;

endmodule
